// ===== src/swld_pkg.sv =====
`timescale 1ns / 1ps

package swld_pkg;

    localparam int TIME_US_W  = 48;
    localparam int COUNT_W    = 32;
    localparam int PERIOD_W   = 24;
    localparam int RUN_W      = 4;
    localparam int CFG_IDX_W  = 2;

    localparam logic [PERIOD_W-1:0] MIN_PERIOD_RST   = 24'd800000;
    localparam logic [PERIOD_W-1:0] MAX_PERIOD_RST   = 24'd1200000;
    localparam logic [RUN_W-1:0]    LOCK_THRESH_RST  = 4'd3;
    localparam logic [PERIOD_W-1:0] LOSS_TIMEOUT_RST = 24'd1500000;

    typedef enum logic {
        CMD_EDGE  = 1'b0,
        CMD_QUERY = 1'b1
    } t_swld_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_PERIOD   = 2'd0,
        CFG_MAX_PERIOD   = 2'd1,
        CFG_LOCK_THRESH  = 2'd2,
        CFG_LOSS_TIMEOUT = 2'd3
    } t_swld_cfg_index;

    typedef struct packed {
        logic                 command;
        logic [TIME_US_W-1:0] time_us;
    } t_swld_in;

    typedef struct packed {
        logic                 raw_valid;
        logic [TIME_US_W-1:0] edge_time_out;
        logic [COUNT_W-1:0]   edge_count_out;
        logic                 signal_present;
        logic                 locked_out;
    } t_swld_out;

    typedef struct packed {
        logic [PERIOD_W-1:0] min_period_us;
        logic [PERIOD_W-1:0] max_period_us;
        logic [RUN_W-1:0]    lock_threshold;
        logic [PERIOD_W-1:0] loss_timeout_us;
    } t_swld_cfg;

endpackage

// ===== src/swld_cfg_regs.sv =====
`timescale 1ns / 1ps

module swld_cfg_regs (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [swld_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [swld_pkg::PERIOD_W-1:0]        i_cfg_data,
    output swld_pkg::t_swld_cfg                  o_cfg
);

    swld_pkg::t_swld_cfg r_cfg;
    swld_pkg::t_swld_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (swld_pkg::t_swld_cfg_index'(i_cfg_index))
                swld_pkg::CFG_MIN_PERIOD:   n_cfg.min_period_us   = i_cfg_data;
                swld_pkg::CFG_MAX_PERIOD:   n_cfg.max_period_us   = i_cfg_data;
                swld_pkg::CFG_LOCK_THRESH:
                    n_cfg.lock_threshold = i_cfg_data[swld_pkg::RUN_W-1:0];
                swld_pkg::CFG_LOSS_TIMEOUT: n_cfg.loss_timeout_us = i_cfg_data;
                default:                    n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_period_us   <= swld_pkg::MIN_PERIOD_RST;
            r_cfg.max_period_us   <= swld_pkg::MAX_PERIOD_RST;
            r_cfg.lock_threshold  <= swld_pkg::LOCK_THRESH_RST;
            r_cfg.loss_timeout_us <= swld_pkg::LOSS_TIMEOUT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== src/square_wave_lock_detector.sv =====
`timescale 1ns / 1ps
// Path: input register, one subtract and window compare, then the result register on o_out_word.
// Throughput: one word per cycle while the result is not held by i_out_stall.
//   While a result waits, the input register takes one more word, then o_in_stall
//   stays high until the waiting result is taken.
// Reset (i_rst_n low, synchronous): pipeline empty, edge history, run and lock cleared,
//   configuration back to its default window, threshold and timeout.

module square_wave_lock_detector #(
    parameter int TIME_WIDTH = 48
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  swld_pkg::t_swld_in              i_in_word,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output swld_pkg::t_swld_out             o_out_word,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [swld_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [swld_pkg::PERIOD_W-1:0]   i_cfg_data
);

    // timebase is used modulo 2^TW
    localparam int TW = (TIME_WIDTH < swld_pkg::TIME_US_W) ? TIME_WIDTH : swld_pkg::TIME_US_W;

    swld_pkg::t_swld_cfg w_cfg;

    swld_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    logic                         r_in_valid;
    swld_pkg::t_swld_in           r_in_word;
    logic                         r_out_valid;
    swld_pkg::t_swld_out          r_out_word;

    logic [TW-1:0]                r_last_edge;
    logic [swld_pkg::COUNT_W-1:0] r_edge_total;
    logic                         r_edge_seen;
    logic [swld_pkg::RUN_W-1:0]   r_run;
    logic                         r_lock;

    logic [TW-1:0]                n_last_edge;
    logic [swld_pkg::COUNT_W-1:0] n_edge_total;
    logic                         n_edge_seen;
    logic [swld_pkg::RUN_W-1:0]   n_run;
    logic                         n_lock;
    swld_pkg::t_swld_out          n_out_word;

    logic                         w_advance;
    logic [TW-1:0]                w_now;
    logic [TW-1:0]                w_elapsed;
    logic                         w_good;
    logic                         w_present;

    assign w_advance   = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !w_advance;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    assign w_now     = r_in_word.time_us[TW-1:0];
    assign w_elapsed = w_now - r_last_edge;
    assign w_good    = (w_elapsed >= TW'(w_cfg.min_period_us)) &&
                       (w_elapsed <= TW'(w_cfg.max_period_us));

    always_comb begin
        n_last_edge  = r_last_edge;
        n_edge_total = r_edge_total;
        n_edge_seen  = r_edge_seen;
        n_run        = r_run;
        n_lock       = r_lock;
        w_present    = 1'b0;
        if (r_in_word.command == swld_pkg::CMD_EDGE) begin
            if (r_edge_seen) begin
                if (!w_good) begin
                    n_run = '0;
                end else if (r_run < w_cfg.lock_threshold) begin
                    n_run = r_run + 1'b1;
                end
                n_lock = (n_run >= w_cfg.lock_threshold);
            end
            n_last_edge  = w_now;
            n_edge_total = r_edge_total + 1'b1;
            n_edge_seen  = 1'b1;
            // elapsed since this very edge is zero
            w_present    = (w_cfg.loss_timeout_us != '0);
        end else begin
            w_present = r_edge_seen && (w_elapsed < TW'(w_cfg.loss_timeout_us));
            if (!w_present) begin
                n_lock = 1'b0;
                n_run  = '0;
            end
        end
        n_out_word.raw_valid      = n_edge_seen;
        n_out_word.edge_time_out  = swld_pkg::TIME_US_W'(n_last_edge);
        n_out_word.edge_count_out = n_edge_total;
        n_out_word.signal_present = w_present;
        n_out_word.locked_out     = w_present && n_lock;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_last_edge  <= '0;
            r_edge_total <= '0;
            r_edge_seen  <= 1'b0;
            r_run        <= '0;
            r_lock       <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid  <= 1'b1;
                r_last_edge  <= n_last_edge;
                r_edge_total <= n_edge_total;
                r_edge_seen  <= n_edge_seen;
                r_run        <= n_run;
                r_lock       <= n_lock;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_word <= i_in_word;
        end
        if (w_advance) begin
            r_out_word <= n_out_word;
        end
    end

    a_lock_needs_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_out_word.locked_out || r_out_word.signal_present))
        else $error("locked result without signal present");

    a_count_on_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in_word.command == swld_pkg::CMD_EDGE)
        |=> (r_edge_total == $past(r_edge_total) + 1'b1))
        else $error("edge count did not step on an edge word");

    a_no_edge_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_word.raw_valid) |-> (r_out_word.edge_count_out == '0))
        else $error("edge count nonzero before any edge");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled with room downstream");

endmodule
